[design/pva_pkg.sv]
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants of the voice allocator
// Opcodes, action codes, envelope phases and the front-to-back command word.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int LEVEL_W = 12;
   localparam int NOTE_W  = 7;
   localparam int AGE_W   = 16;
   localparam int ERR_W   = 15;
   localparam int CSR_W   = 12;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 12'hFFF;
   localparam logic [AGE_W-1:0]   AGE_MAX    = 16'hFFFF;

   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   localparam logic [2:0] ACT_RETRIG  = 3'd0;
   localparam logic [2:0] ACT_FREE    = 3'd1;
   localparam logic [2:0] ACT_STEAL   = 3'd2;
   localparam logic [2:0] ACT_RELEASE = 3'd3;
   localparam logic [2:0] ACT_NOMATCH = 3'd4;
   localparam logic [2:0] ACT_TICK    = 3'd5;

   localparam logic [2:0] PH_OFF = 3'd0;
   localparam logic [2:0] PH_ATK = 3'd1;
   localparam logic [2:0] PH_DCY = 3'd2;
   localparam logic [2:0] PH_SUS = 3'd3;
   localparam logic [2:0] PH_RLS = 3'd4;

   localparam logic [1:0] CSR_ATTACK  = 2'd0;
   localparam logic [1:0] CSR_DECAY   = 2'd1;
   localparam logic [1:0] CSR_SUSTAIN = 2'd2;
   localparam logic [1:0] CSR_RELEASE = 2'd3;

   // command word handed from front to back
   typedef struct packed {
      logic [1:0]        op;
      logic [NOTE_W-1:0] note;
   } cmd_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [2:0]         voice_index;
      logic [NOTE_W-1:0]  voice_note;
      logic [LEVEL_W-1:0] env_level;
      logic [2:0]         env_phase;
      logic               last;
   } rsp_type;

endpackage

[design/pva_stream_if.sv]
// ----------------------------------------------------------------------------
// pva_stream_if: valid/ready channel
// Carries one payload word between a source and a sink.
// ----------------------------------------------------------------------------
interface pva_stream_if #(parameter int W = 9);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[design/pva_front.sv]
// ----------------------------------------------------------------------------
// pva_front: input stage and command queue
// Takes request words, drops unused opcodes and queues the rest for the back.
// ----------------------------------------------------------------------------
module pva_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pva_pkg::cmd_type in_cmd,
   output logic             q_valid,
   input  logic             q_pop,
   output pva_pkg::cmd_type q_cmd
);
   import pva_pkg::*;

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   cmd_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready = (cnt_ff != DEPTH[AW:0]);
   // drop op 3 at the door
   assign push     = in_valid && in_ready && (in_cmd.op != OP_UNUSED);
   assign q_valid  = (cnt_ff != '0);
   assign pop      = q_pop && q_valid;
   assign q_cmd    = mem_ff[rd_ff];

   // advance pointers
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_cmd;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH[AW:0]) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == DEPTH[AW:0]) |-> !push) else $error("push into full queue");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule

[design/pva_divider.sv]
// ----------------------------------------------------------------------------
// pva_divider: serial ceiling-step divider
// Gives floor(dividend/divisor) and the remainder, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pva_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [13:0] dividend,
   input  logic [12:0] divisor,
   output logic        done,
   output logic [13:0] quot,
   output logic [13:0] remd
);
   import pva_pkg::*;

   localparam int QW = 14;

   logic [QW-1:0] q_ff, q_in, d_ff, d_in;
   logic [QW:0]   r_ff, r_in, trial;
   logic [12:0]   s_ff, s_in;
   logic [3:0]    k_ff, k_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   assign trial = {r_ff[QW-1:0], d_ff[QW-1]} - {2'b0, s_ff};
   assign done  = done_ff;
   assign quot  = q_ff;
   assign remd  = r_ff[QW-1:0];

   // restoring division step
   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; s_in = s_ff;
      k_in = k_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         d_in = dividend; s_in = divisor; r_in = '0; q_in = '0;
         k_in = 4'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         d_in = {d_ff[QW-2:0], 1'b0};
         if (!trial[QW]) begin
            r_in = trial;
            q_in = {q_ff[QW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[QW-1:0], d_ff[QW-1]};
            q_in = {q_ff[QW-2:0], 1'b0};
         end
         k_in = k_ff + 1'b1;
         if (k_ff == 4'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         k_ff    <= k_in;
      end
      q_ff <= q_in;
      d_ff <= d_in;
      r_ff <= r_in;
      s_ff <= s_in;
   end

endmodule

[design/pva_back.sv]
// ----------------------------------------------------------------------------
// pva_back: voice table and envelope sequencer
// Runs one queued command at a time: note search, steal scan, aging, and a
// per-voice envelope step through a shared serial divider.
// ----------------------------------------------------------------------------
module pva_back #(
   parameter int VOICES = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_pop,
   input  pva_pkg::cmd_type             q_cmd,
   input  logic [pva_pkg::CSR_W-1:0]    attack_rate,
   input  logic [pva_pkg::CSR_W-1:0]    decay_rate,
   input  logic [pva_pkg::CSR_W-1:0]    sustain_level,
   input  logic [pva_pkg::CSR_W-1:0]    release_rate,
   output logic                         o_valid,
   input  logic                         o_ready,
   output pva_pkg::rsp_type             o_rsp
);
   import pva_pkg::*;

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_ON_SET = 4'd2;
   localparam logic [3:0] S_AGE    = 4'd3;
   localparam logic [3:0] S_EMIT   = 4'd4;
   localparam logic [3:0] S_TLOAD  = 4'd5;
   localparam logic [3:0] S_TDIV   = 4'd6;
   localparam logic [3:0] S_TAPPLY = 4'd7;
   localparam logic [3:0] S_TEMIT  = 4'd8;

   logic [NOTE_W-1:0]         note_ff   [VOICES];
   logic [2:0]                phase_ff  [VOICES];
   logic [LEVEL_W-1:0]        level_ff  [VOICES];
   logic signed [ERR_W-1:0]   err_ff    [VOICES];
   logic [LEVEL_W-1:0]        rstart_ff [VOICES];
   logic [AGE_W-1:0]          age_ff    [VOICES];

   logic [3:0]        st_ff;
   cmd_type           cmd_ff;
   logic [VW-1:0]     idx_ff;
   logic [VW-1:0]     vi;
   logic              mfound_ff, ffound_ff;
   logic [VW-1:0]     mvoice_ff, fvoice_ff, svoice_ff;
   logic [AGE_W-1:0]  best_ff;
   logic              o_valid_ff;
   rsp_type           o_rsp_ff;

   logic              div_start, div_done;
   logic [13:0]       div_dvd, div_q, div_r;
   logic [12:0]       div_dvs;

   assign vi      = idx_ff;
   assign o_valid = o_valid_ff;
   assign o_rsp   = o_rsp_ff;
   assign q_pop   = (st_ff == S_IDLE) && q_valid;

   pva_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dvd),
      .divisor(div_dvs), .done(div_done), .quot(div_q), .remd(div_r)
   );

   // rate and error target of the voice being stepped
   logic [CSR_W-1:0]  cur_rate;
   logic [12:0]       cur_inc;
   logic signed [ERR_W-1:0] cur_err;
   always_comb begin
      cur_err = err_ff[vi];
      case (phase_ff[vi])
         PH_ATK:  begin cur_rate = attack_rate;  cur_inc = {FULL_LEVEL, 1'b0}; end
         PH_DCY:  begin cur_rate = decay_rate;
                        cur_inc = {FULL_LEVEL - sustain_level, 1'b0}; end
         default: begin cur_rate = release_rate; cur_inc = {rstart_ff[vi], 1'b0}; end
      endcase
   end
   assign div_dvd   = 14'(cur_err) - 14'd1 + {cur_rate, 1'b0};
   assign div_dvs   = {cur_rate, 1'b0};
   assign div_start = (st_ff == S_TLOAD) && (phase_ff[vi] != PH_OFF)
                   && (phase_ff[vi] != PH_SUS) && (cur_rate != '0)
                   && cur_err > 0
                   && !(phase_ff[vi] == PH_RLS && level_ff[vi] == '0);

   logic              last_v;
   assign last_v = (idx_ff == VW'(VOICES - 1));

   always_ff @(posedge clock) begin
      logic [LEVEL_W:0]          n;
      logic signed [ERR_W-1:0]   e;
      logic [LEVEL_W+1:0]        sum;
      logic [VW-1:0]             v;
      if (reset) begin
         st_ff      <= S_IDLE;
         o_valid_ff <= 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            note_ff[i]   <= '0;
            phase_ff[i]  <= PH_OFF;
            level_ff[i]  <= '0;
            err_ff[i]    <= '0;
            rstart_ff[i] <= FULL_LEVEL;
            age_ff[i]    <= '0;
         end
      end else begin
         // the tick report state reloads the word register on its own
         if (o_valid_ff && o_ready && st_ff != S_TEMIT) o_valid_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ff    <= q_cmd;
                  idx_ff    <= '0;
                  mfound_ff <= 1'b0;
                  ffound_ff <= 1'b0;
                  best_ff   <= '0;
                  svoice_ff <= '0;
                  st_ff     <= (q_cmd.op == OP_TICK) ? S_TLOAD : S_SCAN;
               end
            end
            // walk voices: note match, first free, oldest
            S_SCAN: begin
               if (!mfound_ff && note_ff[vi] == cmd_ff.note) begin
                  mfound_ff <= 1'b1; mvoice_ff <= vi;
               end
               if (!ffound_ff && phase_ff[vi] == PH_OFF) begin
                  ffound_ff <= 1'b1; fvoice_ff <= vi;
               end
               if (age_ff[vi] > best_ff) begin
                  best_ff <= age_ff[vi]; svoice_ff <= vi;
               end
               if (last_v) st_ff <= S_ON_SET;
               else idx_ff <= idx_ff + 1'b1;
            end
            S_ON_SET: begin
               if (cmd_ff.op == OP_NOTE_ON) begin
                  v = mfound_ff ? mvoice_ff : (ffound_ff ? fvoice_ff : svoice_ff);
                  mvoice_ff <= v;
                  phase_ff[v] <= PH_ATK;
                  age_ff[v]   <= '0;
                  if (!mfound_ff) begin
                     note_ff[v]  <= cmd_ff.note;
                     err_ff[v]   <= '0;
                     level_ff[v] <= '0;
                  end
                  o_rsp_ff.action <= mfound_ff ? ACT_RETRIG
                                   : (ffound_ff ? ACT_FREE : ACT_STEAL);
                  idx_ff <= '0;
                  st_ff  <= S_AGE;
               end else begin
                  if (mfound_ff) begin
                     rstart_ff[mvoice_ff] <= level_ff[mvoice_ff];
                     phase_ff[mvoice_ff]  <= PH_RLS;
                     err_ff[mvoice_ff]    <= '0;
                     o_rsp_ff <= '{ACT_RELEASE, 3'(mvoice_ff), note_ff[mvoice_ff],
                                   level_ff[mvoice_ff], PH_RLS, 1'b1};
                  end else begin
                     o_rsp_ff <= '{ACT_NOMATCH, 3'd0, cmd_ff.note, '0, PH_OFF, 1'b1};
                  end
                  o_valid_ff <= 1'b1;
                  st_ff      <= S_EMIT;
               end
            end
            // age active voices, then report
            S_AGE: begin
               if (phase_ff[vi] != PH_OFF && age_ff[vi] != AGE_MAX)
                  age_ff[vi] <= age_ff[vi] + 1'b1;
               if (last_v) begin
                  o_rsp_ff.voice_index <= 3'(mvoice_ff);
                  o_rsp_ff.voice_note  <= note_ff[mvoice_ff];
                  o_rsp_ff.env_level   <= level_ff[mvoice_ff];
                  o_rsp_ff.env_phase   <= PH_ATK;
                  o_rsp_ff.last        <= 1'b1;
                  o_valid_ff <= 1'b1;
                  st_ff      <= S_EMIT;
               end else idx_ff <= idx_ff + 1'b1;
            end
            S_EMIT: begin
               if (o_ready) st_ff <= S_IDLE;
            end
            S_TLOAD: begin
               st_ff <= div_start ? S_TDIV : S_TAPPLY;
            end
            S_TDIV: begin
               if (div_done) st_ff <= S_TAPPLY;
            end
            // apply one envelope step
            S_TAPPLY: begin
               n = '0;
               e = cur_err;
               if (cur_err > 0) begin
                  n = div_q[LEVEL_W:0];
                  e = $signed(ERR_W'(div_r)) - $signed({2'b0, cur_rate, 1'b0})
                      + 15'sd1;
               end
               case (phase_ff[vi])
                  PH_ATK: begin
                     if (attack_rate == '0) begin
                        level_ff[vi] <= FULL_LEVEL; phase_ff[vi] <= PH_DCY;
                     end else begin
                        sum = {2'b0, level_ff[vi]} + {1'b0, n};
                        if (sum >= {2'b0, FULL_LEVEL}) begin
                           level_ff[vi] <= FULL_LEVEL; err_ff[vi] <= '0;
                           phase_ff[vi] <= PH_DCY;
                        end else begin
                           level_ff[vi] <= sum[LEVEL_W-1:0];
                           err_ff[vi]   <= e + $signed({2'b0, cur_inc});
                        end
                     end
                  end
                  PH_DCY: begin
                     if (decay_rate == '0) begin
                        level_ff[vi] <= sustain_level; phase_ff[vi] <= PH_SUS;
                     end else begin
                        err_ff[vi] <= e + $signed({2'b0, cur_inc});
                        if ({1'b0, level_ff[vi]} <= n + {1'b0, sustain_level}) begin
                           level_ff[vi] <= sustain_level; phase_ff[vi] <= PH_SUS;
                        end else level_ff[vi] <= level_ff[vi] - n[LEVEL_W-1:0];
                     end
                  end
                  PH_RLS: begin
                     if (level_ff[vi] == '0 || release_rate == '0) begin
                        level_ff[vi] <= '0; phase_ff[vi] <= PH_OFF; age_ff[vi] <= '0;
                     end else begin
                        err_ff[vi] <= e + $signed({2'b0, cur_inc});
                        if ({1'b0, level_ff[vi]} <= n) begin
                           level_ff[vi] <= '0; phase_ff[vi] <= PH_OFF;
                           age_ff[vi] <= '0;
                        end else level_ff[vi] <= level_ff[vi] - n[LEVEL_W-1:0];
                     end
                  end
                  default: ;
               endcase
               st_ff <= S_TEMIT;
            end
            S_TEMIT: begin
               if (!o_valid_ff || o_ready) begin
                  o_rsp_ff <= '{ACT_TICK, 3'(vi), note_ff[vi], level_ff[vi],
                                phase_ff[vi], last_v};
                  o_valid_ff <= 1'b1;
                  if (last_v) st_ff <= S_EMIT;
                  else begin
                     idx_ff <= idx_ff + 1'b1;
                     st_ff  <= S_TLOAD;
                  end
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (st_ff == S_IDLE)) else $error("pop while busy");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_EMIT) |-> o_valid_ff) else $error("emit without word");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !o_ready) |=> o_valid_ff) else $error("word dropped");

endmodule

[design/poly_voice_allocator_adsr.sv]
// ----------------------------------------------------------------------------
// poly_voice_allocator_adsr: polyphonic voice table with ADSR envelopes
// Request words (op, note) enter on req_; result words leave on rsp_.
// Note on / note off give one word each; a tick gives one word per voice,
// in voice order, with last set on the final word. Op code 3 gives nothing.
// A four-entry command queue parts the request side from the sequencer: up to
// four requests are taken while the sequencer works or the receiver stalls.
// A tick steps one voice at a time, through the shared serial divider when
// that voice's slope needs a division.
// A stalled receiver holds the result word; the sequencer waits at its next
// report until that word is taken.
// Reset (synchronous) empties the queue, frees all voices and loads the
// register defaults: attack 0, decay 0, sustain 4095, release 0.
// csr_ writes take effect at once and should come only while idle.
// ----------------------------------------------------------------------------
module poly_voice_allocator_adsr #(
   parameter int VOICES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   pva_stream_if.sink                 req,
   pva_stream_if.source               rsp,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [pva_pkg::CSR_W-1:0]  csr_data
);
   import pva_pkg::*;

   logic [CSR_W-1:0] atk_ff, dcy_ff, sus_ff, rls_ff;
   logic             q_valid, q_pop;
   cmd_type          q_cmd, in_cmd;
   rsp_type          o_rsp;

   assign in_cmd = req.data;
   assign rsp.data = o_rsp;

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         atk_ff <= '0;
         dcy_ff <= '0;
         sus_ff <= FULL_LEVEL;
         rls_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ATTACK:  atk_ff <= csr_data;
            CSR_DECAY:   dcy_ff <= csr_data;
            CSR_SUSTAIN: sus_ff <= csr_data;
            CSR_RELEASE: rls_ff <= csr_data;
            default: ;
         endcase
      end
   end

   pva_front u_front (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
   );

   pva_back #(.VOICES(VOICES)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_cmd(q_cmd), .attack_rate(atk_ff), .decay_rate(dcy_ff),
      .sustain_level(sus_ff), .release_rate(rls_ff), .o_valid(rsp.valid),
      .o_ready(rsp.ready), .o_rsp(o_rsp)
   );

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the polyphonic voice allocator
// Drives note on, note off and tick words through several envelope settings.
// Every result word is compared field by field with a SystemVerilog model
// of the voice table that runs alongside the block.
// ----------------------------------------------------------------------------
module testbench;
   import pva_pkg::*;

   localparam int NVOICE   = 8;
   localparam int HALF     = 6;
   localparam int DRAIN    = 200;
   localparam int HOLD_LEN = 600;

   typedef struct {
      logic [1:0]  op;
      logic [6:0]  note;
      bit          typed;
      rsp_type     word;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_ATTACK;
   logic [CSR_W-1:0] csr_data = '0;

   pva_stream_if #(.W(9))  req_if ();
   pva_stream_if #(.W(29)) rsp_if ();

   poly_voice_allocator_adsr #(.VOICES(NVOICE)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // mirror of the voice table and registers
   int attack_r, decay_r, sustain_r, release_r;
   int v_note [NVOICE];
   logic [2:0] v_phase [NVOICE];
   int v_level [NVOICE];
   int v_err [NVOICE];
   int v_rstart [NVOICE];
   int v_age [NVOICE];

   rsp_type expected_words[$];
   int errors = 0;
   int words_checked = 0;
   int items_sent = 0;
   int steals_seen = 0;
   int hold_cycles = 0;

   always #HALF clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
   end

   initial begin
      #(30_000_000);
      $display("Test completed with failures");
      $finish;
   end

   task automatic report(string what, int got, int want);
      errors++;
      $display("MISMATCH word %0d %s: got %0d expected %0d", words_checked, what, got, want);
   endtask

   function automatic void table_reset();
      attack_r = 0; decay_r = 0; sustain_r = 4095; release_r = 0;
      for (int i = 0; i < NVOICE; i++) begin
         v_note[i] = 0; v_phase[i] = PH_OFF; v_level[i] = 0;
         v_err[i] = 0; v_rstart[i] = 4095; v_age[i] = 0;
      end
   endfunction

   function automatic int slope(int v, int step);
      int n;
      n = 0;
      if (v_err[v] > 0) begin
         n = (v_err[v] + step - 1) / step;
         v_err[v] -= n * step;
      end
      return n;
   endfunction

   function automatic void free_up(int v);
      v_level[v] = 0;
      v_phase[v] = PH_OFF;
      v_age[v] = 0;
   endfunction

   // step one envelope by one tick
   function automatic void envelope_tick(int v);
      int n;
      case (v_phase[v])
         PH_ATK: begin
            if (attack_r == 0) begin
               v_level[v] = 4095; v_phase[v] = PH_DCY;
            end else begin
               n = slope(v, 2 * attack_r);
               v_err[v] += 2 * 4095;
               if (v_level[v] + n >= 4095) begin
                  v_level[v] = 4095; v_err[v] = 0; v_phase[v] = PH_DCY;
               end else v_level[v] += n;
            end
         end
         PH_DCY: begin
            if (decay_r == 0) begin
               v_level[v] = sustain_r; v_phase[v] = PH_SUS;
            end else begin
               n = slope(v, 2 * decay_r);
               v_err[v] += 2 * (4095 - sustain_r);
               if (v_level[v] - n <= sustain_r) begin
                  v_level[v] = sustain_r; v_phase[v] = PH_SUS;
               end else v_level[v] -= n;
            end
         end
         PH_RLS: begin
            if (v_level[v] <= 0 || release_r == 0) free_up(v);
            else begin
               n = slope(v, 2 * release_r);
               v_err[v] += 2 * v_rstart[v];
               if (v_level[v] - n <= 0) free_up(v);
               else v_level[v] -= n;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_type make_word(logic [2:0] act, int v, int nt, int lev,
                                         logic [2:0] ph, logic lst);
      rsp_type w;
      w.action = act; w.voice_index = v[2:0]; w.voice_note = nt[6:0];
      w.env_level = lev[11:0]; w.env_phase = ph; w.last = lst;
      return w;
   endfunction

   // advance the table by one request and queue the words it yields
   function automatic void predict_words(logic [1:0] op, int nt);
      int v;
      logic [2:0] act;
      int best;
      v = NVOICE;
      case (op)
         OP_NOTE_ON: begin
            for (int i = NVOICE - 1; i >= 0; i--) if (v_note[i] == nt) v = i;
            if (v < NVOICE) begin
               act = ACT_RETRIG; v_phase[v] = PH_ATK; v_age[v] = 0;
            end else begin
               for (int i = NVOICE - 1; i >= 0; i--) if (v_phase[i] == PH_OFF) v = i;
               if (v < NVOICE) act = ACT_FREE;
               else begin
                  act = ACT_STEAL; best = 0; v = 0;
                  for (int i = 0; i < NVOICE; i++)
                     if (v_age[i] > best) begin best = v_age[i]; v = i; end
                  steals_seen++;
               end
               v_note[v] = nt; v_err[v] = 0; v_level[v] = 0;
               v_phase[v] = PH_ATK; v_age[v] = 0;
            end
            for (int i = 0; i < NVOICE; i++)
               if (v_phase[i] != PH_OFF && v_age[i] < 65535) v_age[i]++;
            expected_words.push_back(make_word(act, v, v_note[v], v_level[v],
                                               v_phase[v], 1'b1));
         end
         OP_NOTE_OFF: begin
            for (int i = NVOICE - 1; i >= 0; i--) if (v_note[i] == nt) v = i;
            if (v < NVOICE) begin
               v_rstart[v] = v_level[v]; v_phase[v] = PH_RLS; v_err[v] = 0;
               expected_words.push_back(make_word(ACT_RELEASE, v, v_note[v],
                                                  v_level[v], v_phase[v], 1'b1));
            end else
               expected_words.push_back(make_word(ACT_NOMATCH, 0, nt, 0, PH_OFF, 1'b1));
         end
         OP_TICK: begin
            for (int i = 0; i < NVOICE; i++) begin
               envelope_tick(i);
               expected_words.push_back(make_word(ACT_TICK, i, v_note[i], v_level[i],
                                                  v_phase[i], i == NVOICE - 1));
            end
         end
         default: ;
      endcase
   endfunction

   // offer one request word, hold it until taken
   task automatic send_word(logic [1:0] op, logic [6:0] nt, bit typed, rsp_type tw);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      req_if.valid = 1'b1;
      req_if.data  = {op, nt};
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      if (typed) begin
         predict_words(op, nt);
         void'(expected_words.pop_back());
         expected_words.push_back(tw);
      end else predict_words(op, nt);
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic write_reg(logic [1:0] idx, int value);
      csr_we = 1'b1; csr_index = idx; csr_data = value[11:0];
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_ATTACK:  attack_r  = value;
         CSR_DECAY:   decay_r   = value;
         CSR_SUSTAIN: sustain_r = value;
         default:     release_r = value;
      endcase
   endtask

   task automatic drain();
      while (expected_words.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   // receiver stalls: random gaps, or a long hold-off on request
   initial begin
      int stall;
      stall = 0;
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_if.ready = 1'b0; hold_cycles--;
         end else if (stall > 0) begin
            rsp_if.ready = 1'b0; stall--;
         end else begin
            rsp_if.ready = 1'b1;
            if ($urandom_range(0, 7) == 0)
               stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
         end
         @(negedge clock);
      end
   end

   // check every accepted result word against the oldest expectation
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (expected_words.size() == 0) begin
            errors++;
            $display("UNEXPECTED result word %h", got);
         end else begin
            want = expected_words.pop_front();
            if (got.action != want.action) report("action", got.action, want.action);
            if (got.voice_index != want.voice_index)
               report("voice_index", got.voice_index, want.voice_index);
            if (got.voice_note != want.voice_note)
               report("voice_note", got.voice_note, want.voice_note);
            if (got.env_level != want.env_level)
               report("env_level", got.env_level, want.env_level);
            if (got.env_phase != want.env_phase)
               report("env_phase", got.env_phase, want.env_phase);
            if (got.last != want.last) report("last", got.last, want.last);
         end
         words_checked++;
      end
   end

   initial begin
      stim_row_type rows[$];
      rsp_type nw;
      int cfg [5][4];
      logic [1:0] op;
      int nt, pick;

      table_reset();
      nw = '0;
      // directed rows after reset; typed where obvious
      rows.push_back('{OP_NOTE_ON, 7'd5, 1, make_word(ACT_FREE, 0, 5, 0, PH_ATK, 1)});
      rows.push_back('{OP_NOTE_ON, 7'd0, 1, make_word(ACT_RETRIG, 1, 0, 0, PH_ATK, 1)});
      rows.push_back('{OP_NOTE_OFF, 7'd99, 1, make_word(ACT_NOMATCH, 0, 99, 0, PH_OFF, 1)});
      rows.push_back('{OP_NOTE_OFF, 7'd5, 1, make_word(ACT_RELEASE, 0, 5, 0, PH_RLS, 1)});
      rows.push_back('{OP_TICK, 7'd0, 0, nw});
      rows.push_back('{OP_UNUSED, 7'd127, 0, nw});
      rows.push_back('{OP_NOTE_ON, 7'd127, 0, nw});
      rows.push_back('{OP_TICK, 7'd127, 0, nw});
      for (int i = 0; i < 9; i++) rows.push_back('{OP_NOTE_ON, 7'(20 + i), 0, nw});
      rows.push_back('{OP_NOTE_ON, 7'd127, 0, nw});
      rows.push_back('{OP_TICK, 7'd0, 0, nw});
      rows.push_back('{OP_NOTE_OFF, 7'd127, 0, nw});
      rows.push_back('{OP_NOTE_OFF, 7'd21, 0, nw});
      rows.push_back('{OP_TICK, 7'd0, 0, nw});
      rows.push_back('{OP_TICK, 7'd0, 0, nw});

      repeat (4) @(negedge clock);
      reset = 1'b0;
      repeat (DRAIN) @(negedge clock);

      foreach (rows[r]) send_word(rows[r].op, rows[r].note, rows[r].typed, rows[r].word);

      cfg = '{'{4095, 4095, 0, 4095}, '{1, 1, 2048, 1}, '{0, 0, 4095, 0},
              '{12, 30, 1000, 20}, '{0, 0, 0, 0}};
      cfg[4][0] = $urandom_range(0, 4095); cfg[4][1] = $urandom_range(0, 4095);
      cfg[4][2] = $urandom_range(0, 4095); cfg[4][3] = $urandom_range(0, 4095);

      for (int p = 0; p < 5; p++) begin
         drain();
         write_reg(CSR_ATTACK,  cfg[p][0]);
         write_reg(CSR_DECAY,   cfg[p][1]);
         write_reg(CSR_SUSTAIN, cfg[p][2]);
         write_reg(CSR_RELEASE, cfg[p][3]);
         for (int k = 0; k < 100; k++) begin
            // long receiver hold-off while requests keep coming
            if (p == 1 && k == 10) hold_cycles = HOLD_LEN;
            pick = $urandom_range(0, 99);
            if (pick < 40) op = OP_NOTE_ON;
            else if (pick < 68) op = OP_NOTE_OFF;
            else if (pick < 98) op = OP_TICK;
            else op = OP_UNUSED;
            nt = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 11) : $urandom_range(0, 127);
            send_word(op, nt[6:0], 0, nw);
         end
      end

      drain();
      $display("Sent %0d request words over 6 settings, checked %0d result words, %0d steals",
               items_sent, words_checked, steals_seen);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[filelist.f]
design/pva_pkg.sv
design/pva_stream_if.sv
design/pva_front.sv
design/pva_divider.sv
design/pva_back.sv
design/poly_voice_allocator_adsr.sv
verif/testbench.sv
